// ===== src/irtx_pkg.sv =====
package irtx_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int IN_DATA_W  = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEC_HALF      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SONY_HALF     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SONY_BITS     = 2'd3;

	localparam logic [5:0] NEC_HALF_RST  = 6'd13;
	localparam logic [5:0] SONY_HALF_RST = 6'd12;
	localparam logic [5:0] SONY_BITS_RST = 6'd12;

	localparam logic [5:0] NEC_BITS      = 6'd32;
	localparam logic [5:0] SONY_MAX_BITS = 6'd32;

	localparam logic [8:0] NEC_HDR_CYCLES   = 9'd342;
	localparam logic [8:0] NEC_BIT_CYCLES   = 9'd21;
	localparam logic [8:0] SONY_HDR_CYCLES  = 9'd96;
	localparam logic [8:0] SONY_CYCLES_ZERO = 9'd24;
	localparam logic [8:0] SONY_CYCLES_ONE  = 9'd48;

	localparam logic [12:0] NEC_HDR_SPACE  = 13'd4500;
	localparam logic [12:0] NEC_SPACE_ZERO = 13'd562;
	localparam logic [12:0] NEC_SPACE_ONE  = 13'd1687;
	localparam logic [12:0] SONY_HDR_SPACE = 13'd600;
	localparam logic [12:0] SONY_BIT_SPACE = 13'd600;

	typedef struct packed {
		logic       protocol_mode;
		logic [5:0] nec_carrier_half_us;
		logic [5:0] sony_carrier_half_us;
		logic [5:0] sony_frame_bits;
	} cfg_t;

	typedef struct packed {
		logic ir_out;
		logic busy_res;
		logic frame_done;
	} res_t;

	// carrier half period for a mode; zero acts as one
	function automatic logic [5:0] half_us(input logic mode, input cfg_t c);
		logic [5:0] h;
		h = mode ? c.sony_carrier_half_us : c.nec_carrier_half_us;
		return (h == 6'd0) ? 6'd1 : h;
	endfunction

endpackage

// ===== src/irtx_in_if.sv =====
interface irtx_in_if;
	logic                           valid;
	logic                           ready;
	logic                           tick;
	logic                           start_req;
	logic [irtx_pkg::IN_DATA_W-1:0] frame_data;

	modport source (output valid, tick, start_req, frame_data, input ready);
	modport sink   (input valid, tick, start_req, frame_data, output ready);
endinterface

// ===== src/irtx_out_if.sv =====
interface irtx_out_if;
	logic valid;
	logic ready;
	logic ir_out;
	logic busy_res;
	logic frame_done;

	modport source (output valid, ir_out, busy_res, frame_done, input ready);
	modport sink   (input valid, ir_out, busy_res, frame_done, output ready);
endinterface

// ===== src/irtx_cfg_if.sv =====
interface irtx_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [irtx_pkg::CFG_IDX_W-1:0]  index;
	logic [irtx_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/irtx_cfg_regs.sv =====
module irtx_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	irtx_cfg_if.sink        cfg,
	output irtx_pkg::cfg_t  regs
);
	irtx_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.protocol_mode        <= 1'b0;
			regs_q.nec_carrier_half_us  <= irtx_pkg::NEC_HALF_RST;
			regs_q.sony_carrier_half_us <= irtx_pkg::SONY_HALF_RST;
			regs_q.sony_frame_bits      <= irtx_pkg::SONY_BITS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				irtx_pkg::REG_PROTOCOL_MODE: regs_q.protocol_mode        <= cfg.data[0];
				irtx_pkg::REG_NEC_HALF:      regs_q.nec_carrier_half_us  <= cfg.data;
				irtx_pkg::REG_SONY_HALF:     regs_q.sony_carrier_half_us <= cfg.data;
				irtx_pkg::REG_SONY_BITS:     regs_q.sony_frame_bits      <= cfg.data;
				default: ;
			endcase
		end
	end
endmodule

// ===== src/irtx_seq.sv =====
module irtx_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           tick,
	input  logic                           start_req,
	input  logic [irtx_pkg::IN_DATA_W-1:0] frame_data,
	input  irtx_pkg::cfg_t                 regs,
	output irtx_pkg::res_t                 res
);
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_HDR_BURST = 3'd1;
	localparam logic [2:0] PH_HDR_SPACE = 3'd2;
	localparam logic [2:0] PH_BIT_BURST = 3'd3;
	localparam logic [2:0] PH_BIT_SPACE = 3'd4;
	localparam logic [2:0] PH_CLOSE     = 3'd5;

	logic                           mode_q, mode_d;
	logic [irtx_pkg::DATA_WIDTH-1:0] shift_q, shift_d;
	logic [5:0]                     bits_q, bits_d;
	logic [2:0]                     ph_q, ph_d;
	logic [8:0]                     cyc_q, cyc_d;
	logic [12:0]                    sp_q, sp_d;
	logic [5:0]                     hc_q, hc_d;
	logic                           lvl_q, lvl_d;

	logic       seg_end, bit_go, fin, done;
	logic [5:0] hp_run, hp_start;

	assign hp_run   = irtx_pkg::half_us(mode_q, regs);
	assign hp_start = irtx_pkg::half_us(regs.protocol_mode, regs);

	always_comb begin
		mode_d  = mode_q;
		shift_d = shift_q;
		bits_d  = bits_q;
		ph_d    = ph_q;
		cyc_d   = cyc_q;
		sp_d    = sp_q;
		hc_d    = hc_q;
		lvl_d   = lvl_q;
		seg_end = 1'b0;
		bit_go  = 1'b0;
		fin     = 1'b0;

		if (ph_q == PH_IDLE) begin
			if (start_req) begin
				mode_d  = regs.protocol_mode;
				shift_d = irtx_pkg::DATA_WIDTH'(frame_data);
				ph_d    = PH_HDR_BURST;
				lvl_d   = 1'b1;
				hc_d    = hp_start;
				if (regs.protocol_mode) begin
					bits_d = (regs.sony_frame_bits > irtx_pkg::SONY_MAX_BITS) ?
						irtx_pkg::SONY_MAX_BITS : regs.sony_frame_bits;
					cyc_d  = irtx_pkg::SONY_HDR_CYCLES;
				end else begin
					bits_d = irtx_pkg::NEC_BITS;
					cyc_d  = irtx_pkg::NEC_HDR_CYCLES;
				end
			end
		end else if (tick) begin
			case (ph_q)
				PH_HDR_BURST, PH_BIT_BURST, PH_CLOSE: begin
					hc_d = hc_q - 6'd1;
					if (hc_d == 6'd0) begin
						if (lvl_q) begin
							lvl_d = 1'b0;
							hc_d  = hp_run;
						end else begin
							cyc_d = cyc_q - 9'd1;
							if (cyc_d == 9'd0) begin
								seg_end = 1'b1;
							end else begin
								lvl_d = 1'b1;
								hc_d  = hp_run;
							end
						end
					end
				end
				PH_HDR_SPACE, PH_BIT_SPACE: begin
					sp_d = sp_q - 13'd1;
					if (sp_d == 13'd0)
						seg_end = 1'b1;
				end
				default: fin = 1'b1;
			endcase

			if (seg_end) begin
				case (ph_q)
					PH_HDR_BURST: begin
						ph_d  = PH_HDR_SPACE;
						lvl_d = 1'b0;
						sp_d  = mode_q ? irtx_pkg::SONY_HDR_SPACE : irtx_pkg::NEC_HDR_SPACE;
					end
					PH_HDR_SPACE: begin
						if (bits_q == 6'd0)
							fin = 1'b1;
						else
							bit_go = 1'b1;
					end
					PH_BIT_BURST: begin
						ph_d  = PH_BIT_SPACE;
						lvl_d = 1'b0;
						if (mode_q)
							sp_d = irtx_pkg::SONY_BIT_SPACE;
						else
							sp_d = shift_q[0] ? irtx_pkg::NEC_SPACE_ONE :
								irtx_pkg::NEC_SPACE_ZERO;
					end
					PH_BIT_SPACE: begin
						shift_d = shift_q >> 1;
						bits_d  = bits_q - 6'd1;
						if (bits_d != 6'd0) begin
							bit_go = 1'b1;
						end else if (mode_q) begin
							fin = 1'b1;
						end else begin
							// NEC closing burst
							ph_d  = PH_CLOSE;
							cyc_d = irtx_pkg::NEC_BIT_CYCLES;
							lvl_d = 1'b1;
							hc_d  = hp_run;
						end
					end
					default: fin = 1'b1;
				endcase
			end

			if (bit_go) begin
				ph_d  = PH_BIT_BURST;
				lvl_d = 1'b1;
				hc_d  = hp_run;
				if (mode_q)
					cyc_d = shift_d[0] ? irtx_pkg::SONY_CYCLES_ONE : irtx_pkg::SONY_CYCLES_ZERO;
				else
					cyc_d = irtx_pkg::NEC_BIT_CYCLES;
			end

			if (fin) begin
				ph_d  = PH_IDLE;
				lvl_d = 1'b0;
				hc_d  = 6'd0;
				cyc_d = 9'd0;
				sp_d  = 13'd0;
			end
		end
		done = fin;
	end

	assign res.ir_out     = lvl_d &&
		(ph_d == PH_HDR_BURST || ph_d == PH_BIT_BURST || ph_d == PH_CLOSE);
	assign res.busy_res   = (ph_d != PH_IDLE);
	assign res.frame_done = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			shift_q <= '0;
			bits_q  <= 6'd0;
			ph_q    <= PH_IDLE;
			cyc_q   <= 9'd0;
			sp_q    <= 13'd0;
			hc_q    <= 6'd0;
			lvl_q   <= 1'b0;
		end else if (en) begin
			mode_q  <= mode_d;
			shift_q <= shift_d;
			bits_q  <= bits_d;
			ph_q    <= ph_d;
			cyc_q   <= cyc_d;
			sp_q    <= sp_d;
			hc_q    <= hc_d;
			lvl_q   <= lvl_d;
		end
	end
endmodule

// ===== src/ir_remote_frame_transmitter.sv =====
// NEC / Sony SIRC infrared frame transmitter. Every input beat is one clock step carrying the
// microsecond tick, a start request and a data word; every input beat yields exactly one
// result beat with the emitter level, busy flag and frame-done pulse after that step. The
// block takes one beat per cycle: an input register feeds the frame sequencer, whose next
// state and result are written into the result register in the same cycle, and throughput
// is held back only by result-side backpressure. Configuration writes are always accepted
// (ready is tied high) and must only be issued while idle.
module ir_remote_frame_transmitter (
	input  logic          clk,
	input  logic          arst_n,
	irtx_in_if.sink       item_in,
	irtx_out_if.source    result_out,
	irtx_cfg_if.sink      cfg
);
	irtx_pkg::cfg_t regs;
	irtx_pkg::res_t res_d, res_s2;

	logic                           valid_s1, valid_s2;
	logic                           tick_s1, start_s1;
	logic [irtx_pkg::IN_DATA_W-1:0] data_s1;
	logic                           adv_s1;

	irtx_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// stage 1 moves into the result register when that register is free or drains
	assign adv_s1        = valid_s1 && (!valid_s2 || result_out.ready);
	assign item_in.ready = !valid_s1 || adv_s1;

	irtx_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv_s1),
		.tick       (tick_s1),
		.start_req  (start_s1),
		.frame_data (data_s1),
		.regs       (regs),
		.res        (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_in.ready)
				valid_s1 <= item_in.valid;
			if (!valid_s2 || result_out.ready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.ready && item_in.valid) begin
			tick_s1  <= item_in.tick;
			start_s1 <= item_in.start_req;
			data_s1  <= item_in.frame_data;
		end
		if (adv_s1)
			res_s2 <= res_d;
	end

	assign result_out.valid      = valid_s2;
	assign result_out.ir_out     = res_s2.ir_out;
	assign result_out.busy_res   = res_s2.busy_res;
	assign result_out.frame_done = res_s2.frame_done;

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.frame_done |-> !res_s2.busy_res)
		else $error("frame_done reported while still busy");

	a_ir_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.ir_out |-> res_s2.busy_res)
		else $error("emitter driven outside a frame");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(data_s1))
		else $error("stage 1 beat lost under backpressure");
endmodule

// ===== tb/sv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RUN_LIMIT      = 100_000;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int PRINT_LIMIT    = 25;

	typedef enum logic [2:0] {
		SEG_IDLE, SEG_HDR_BURST, SEG_HDR_SPACE, SEG_BIT_BURST, SEG_BIT_SPACE, SEG_CLOSE
	} seg_t;

	typedef struct packed {
		logic                           tick;
		logic                           start_req;
		logic [irtx_pkg::IN_DATA_W-1:0] frame_data;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;

	irtx_in_if  item_in ();
	irtx_out_if result_out ();
	irtx_cfg_if cfg ();

	ir_remote_frame_transmitter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.result_out (result_out),
		.cfg        (cfg)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	step_t           steps_queued[$];
	irtx_pkg::res_t  expected_res[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int steps_checked = 0;
	int nec_frames = 0;
	int sony_frames = 0;
	int frames_sent = 0;
	int reg_writes = 0;
	int cycles_run = 0;
	int hold_left;
	logic hold_arm = 1'b0;
	logic hold_used;

	// ticks still to go in the frame being generated
	int ticks_left = 0;
	bit frame_open = 1'b0;

	// transmitter model state
	irtx_pkg::cfg_t                  reg_shadow;
	logic                            tx_sony;
	logic [irtx_pkg::DATA_WIDTH-1:0] tx_bits;
	logic [5:0]                      tx_left;
	seg_t                            tx_seg;
	logic [8:0]                      tx_cycles;
	logic [12:0]                     tx_space;
	logic [5:0]                      tx_half;
	logic                            tx_level;
	logic                            tx_done;

	function automatic logic [5:0] carrier_half();
		logic [5:0] h;
		h = tx_sony ? reg_shadow.sony_carrier_half_us : reg_shadow.nec_carrier_half_us;
		return (h == 6'd0) ? 6'd1 : h;
	endfunction

	function automatic void burst_open(input seg_t seg, input logic [8:0] cycles);
		tx_seg = seg;
		tx_cycles = cycles;
		tx_level = 1'b1;
		tx_half = carrier_half();
	endfunction

	function automatic void space_open(input seg_t seg, input logic [12:0] us);
		tx_seg = seg;
		tx_space = us;
		tx_level = 1'b0;
	endfunction

	function automatic void bit_open();
		if (tx_sony)
			burst_open(SEG_BIT_BURST,
				tx_bits[0] ? irtx_pkg::SONY_CYCLES_ONE : irtx_pkg::SONY_CYCLES_ZERO);
		else
			burst_open(SEG_BIT_BURST, irtx_pkg::NEC_BIT_CYCLES);
	endfunction

	function automatic void frame_close();
		tx_seg = SEG_IDLE;
		tx_level = 1'b0;
		tx_half = '0;
		tx_cycles = '0;
		tx_space = '0;
		tx_done = 1'b1;
	endfunction

	function automatic void segment_end();
		case (tx_seg)
			SEG_HDR_BURST: space_open(SEG_HDR_SPACE,
				tx_sony ? irtx_pkg::SONY_HDR_SPACE : irtx_pkg::NEC_HDR_SPACE);
			SEG_HDR_SPACE: begin
				if (tx_left == 6'd0)
					frame_close();
				else
					bit_open();
			end
			SEG_BIT_BURST: begin
				if (tx_sony)
					space_open(SEG_BIT_SPACE, irtx_pkg::SONY_BIT_SPACE);
				else
					space_open(SEG_BIT_SPACE,
						tx_bits[0] ? irtx_pkg::NEC_SPACE_ONE : irtx_pkg::NEC_SPACE_ZERO);
			end
			SEG_BIT_SPACE: begin
				tx_bits = tx_bits >> 1;
				tx_left = tx_left - 6'd1;
				if (tx_left != 6'd0)
					bit_open();
				else if (tx_sony)
					frame_close();
				else
					burst_open(SEG_CLOSE, irtx_pkg::NEC_BIT_CYCLES);
			end
			default: frame_close();
		endcase
	endfunction

	// advance the transmitter by one step and return the emitter state after it
	function automatic irtx_pkg::res_t tx_step(input logic tick, input logic start,
			input logic [irtx_pkg::IN_DATA_W-1:0] data);
		irtx_pkg::res_t r;
		tx_done = 1'b0;
		if (tx_seg == SEG_IDLE) begin
			if (start) begin
				tx_sony = reg_shadow.protocol_mode;
				tx_bits = data;
				if (tx_sony) begin
					tx_left = (reg_shadow.sony_frame_bits > irtx_pkg::SONY_MAX_BITS) ?
						irtx_pkg::SONY_MAX_BITS : reg_shadow.sony_frame_bits;
					burst_open(SEG_HDR_BURST, irtx_pkg::SONY_HDR_CYCLES);
				end else begin
					tx_left = irtx_pkg::NEC_BITS;
					burst_open(SEG_HDR_BURST, irtx_pkg::NEC_HDR_CYCLES);
				end
			end
		end else if (tick) begin
			case (tx_seg)
				SEG_HDR_BURST, SEG_BIT_BURST, SEG_CLOSE: begin
					tx_half = tx_half - 6'd1;
					if (tx_half == 6'd0) begin
						if (tx_level) begin
							tx_level = 1'b0;
							tx_half = carrier_half();
						end else begin
							tx_cycles = tx_cycles - 9'd1;
							if (tx_cycles == 9'd0) begin
								segment_end();
							end else begin
								tx_level = 1'b1;
								tx_half = carrier_half();
							end
						end
					end
				end
				SEG_HDR_SPACE, SEG_BIT_SPACE: begin
					tx_space = tx_space - 13'd1;
					if (tx_space == 13'd0)
						segment_end();
				end
				default: frame_close();
			endcase
		end
		r.ir_out = tx_level && (tx_seg inside {SEG_HDR_BURST, SEG_BIT_BURST, SEG_CLOSE});
		r.busy_res = (tx_seg != SEG_IDLE);
		r.frame_done = tx_done;
		return r;
	endfunction

	task automatic log_mismatch(input string what);
		if (mismatches < PRINT_LIMIT)
			$display("MISMATCH at result %0d: %s", steps_checked, what);
		mismatches++;
	endtask

	// driver: offer the next queued step, hold it until taken
	always @(posedge clk or negedge arst_n) begin
		step_t outgoing;
		if (!arst_n) begin
			item_in.valid <= 1'b0;
			item_in.tick <= 1'b0;
			item_in.start_req <= 1'b0;
			item_in.frame_data <= '0;
		end else if (!item_in.valid || item_in.ready) begin
			if (steps_queued.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				outgoing = steps_queued.pop_front();
				item_in.valid <= 1'b1;
				item_in.tick <= outgoing.tick;
				item_in.start_req <= outgoing.start_req;
				item_in.frame_data <= outgoing.frame_data;
			end else begin
				item_in.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_arm && !hold_used) begin
			hold_left <= RX_HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_out.ready <= 1'b0;
		else
			result_out.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
	end

	// monitor: compare before predicting, a result never belongs to the beat taken this edge
	always @(posedge clk) begin
		irtx_pkg::res_t seen;
		irtx_pkg::res_t want;
		if (arst_n) begin
			if (result_out.valid === 1'b1 && result_out.ready === 1'b1) begin
				seen.ir_out = result_out.ir_out;
				seen.busy_res = result_out.busy_res;
				seen.frame_done = result_out.frame_done;
				if (expected_res.size() == 0) begin
					log_mismatch($sformatf("unexpected result %b", seen));
				end else begin
					want = expected_res.pop_front();
					if (seen.ir_out !== want.ir_out)
						log_mismatch($sformatf("ir_out %b, want %b", seen.ir_out, want.ir_out));
					if (seen.busy_res !== want.busy_res)
						log_mismatch($sformatf("busy_res %b, want %b",
							seen.busy_res, want.busy_res));
					if (seen.frame_done !== want.frame_done)
						log_mismatch($sformatf("frame_done %b, want %b",
							seen.frame_done, want.frame_done));
				end
				steps_checked++;
			end
			if (item_in.valid === 1'b1 && item_in.ready === 1'b1) begin
				want = tx_step(item_in.tick, item_in.start_req, item_in.frame_data);
				expected_res.push_back(want);
				if (want.frame_done) begin
					frames_sent++;
					if (tx_sony)
						sony_frames++;
					else
						nec_frames++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles_run++;
		if (cycles_run == RUN_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d results pending",
				cycles_run, expected_res.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic void push_step(input logic tick, input logic start,
			input logic [irtx_pkg::IN_DATA_W-1:0] data);
		step_t s;
		s.tick = tick;
		s.start_req = start;
		s.frame_data = data;
		steps_queued.push_back(s);
	endfunction

	// ticks in a one-bit Sony frame at a one-tick half period, start step excluded
	function automatic int sony_frame_ticks(input logic bit0);
		int burst;
		burst = bit0 ? int'(irtx_pkg::SONY_CYCLES_ONE) : int'(irtx_pkg::SONY_CYCLES_ZERO);
		return 2 * int'(irtx_pkg::SONY_HDR_CYCLES) + int'(irtx_pkg::SONY_HDR_SPACE) +
			2 * burst + int'(irtx_pkg::SONY_BIT_SPACE);
	endfunction

	// random step, inside the open frame or after it; starts while busy are sprinkled in, one lands on
	// the step that ends the frame, and none follow it
	function automatic void push_frame_step();
		logic tick;
		logic start;
		tick = ($urandom_range(31) != 0);
		start = ($urandom_range(7) == 0);
		if (!frame_open) begin
			start = 1'b0;
		end else if (tick) begin
			ticks_left--;
			if (ticks_left == 0) begin
				start = 1'b1;
				frame_open = 1'b0;
			end
		end
		push_step(tick, start, $urandom);
	endfunction

	// let the queue run dry, then switch the traffic rates for the next stretch of steps
	task automatic push_traffic(input int count, input int idle_pct, input int stall);
		while (steps_queued.size() != 0)
			@(negedge clk);
		send_idle_pct = idle_pct;
		stall_pct = stall;
		repeat (count) push_frame_step();
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (steps_queued.size() != 0 || item_in.valid !== 1'b0 || expected_res.size() != 0);
	endtask

	task automatic write_reg(input logic [irtx_pkg::CFG_IDX_W-1:0] idx,
			input logic [irtx_pkg::CFG_DATA_W-1:0] val);
		wait_drained();
		repeat (4) @(negedge clk);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do
			@(posedge clk);
		while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		case (idx)
			irtx_pkg::REG_PROTOCOL_MODE: reg_shadow.protocol_mode = val[0];
			irtx_pkg::REG_NEC_HALF:      reg_shadow.nec_carrier_half_us = val;
			irtx_pkg::REG_SONY_HALF:     reg_shadow.sony_carrier_half_us = val;
			irtx_pkg::REG_SONY_BITS:     reg_shadow.sony_frame_bits = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	initial begin
		logic [irtx_pkg::IN_DATA_W-1:0] sony_data;
		arst_n = 1'b0;
		item_in.valid = 1'b0;
		item_in.tick = 1'b0;
		item_in.start_req = 1'b0;
		item_in.frame_data = '0;
		result_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		reg_shadow = '{1'b0, irtx_pkg::NEC_HALF_RST, irtx_pkg::SONY_HALF_RST,
			irtx_pkg::SONY_BITS_RST};
		tx_sony = 1'b0;
		tx_bits = '0;
		tx_left = '0;
		tx_seg = SEG_IDLE;
		tx_cycles = '0;
		tx_space = '0;
		tx_half = '0;
		tx_level = 1'b0;
		tx_done = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Sony with a zero half period and one data bit, run through every traffic mix
		write_reg(irtx_pkg::REG_PROTOCOL_MODE, 6'd1);
		write_reg(irtx_pkg::REG_SONY_HALF, 6'd0);
		write_reg(irtx_pkg::REG_SONY_BITS, 6'd1);
		sony_data = $urandom;
		push_step(1'b1, 1'b0, '1);
		push_step(1'b1, 1'b1, sony_data);
		ticks_left = sony_frame_ticks(sony_data[0]);
		frame_open = 1'b1;
		push_traffic(300, 0, 0);
		hold_arm <= 1'b1;
		push_traffic(300, 74, 0);
		push_traffic(300, 0, 74);
		push_traffic(600, 23, 23);
		while (frame_open)
			push_traffic(16, 0, 0);
		push_traffic(8, 0, 0);

		// NEC at the reset half period: start on a step with no tick, stalled ticks,
		// a start while busy, then new half periods picked up mid-frame
		write_reg(irtx_pkg::REG_PROTOCOL_MODE, 6'd0);
		push_step(1'b0, 1'b1, $urandom);
		repeat (3) push_step(1'b0, 1'b0, '1);
		push_step(1'b1, 1'b1, '1);
		repeat (14) push_step(1'b1, 1'b0, $urandom);
		write_reg(irtx_pkg::REG_NEC_HALF, 6'd0);
		repeat (80) push_step(1'b1, $urandom_range(15) == 0, $urandom);
		write_reg(irtx_pkg::REG_NEC_HALF, 6'd2);
		repeat (40) push_step(1'b1, 1'b0, $urandom);

		wait_drained();
		repeat (8) @(negedge clk);
		$display("Checked %0d steps over %0d NEC and %0d Sony frames, %0d register writes.",
			steps_checked, nec_frames, sony_frames, reg_writes);
		$display("Traffic ran with sender gaps, receiver stalls and one long receiver hold.");
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
